// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each use samples on the rising edge of clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/dd2f_pkg.sv -----
package dd2f_pkg;

  localparam int FRAC_DIGITS_DEF      = 7;
  localparam int MAX_WHOLE_DIGITS_DEF = 10;

  localparam int LAT_LIMIT_DEG = 90;
  localparam int LON_LIMIT_DEG = 180;
  localparam int LIMIT_W       = 8;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Control flags of a finished token, handed from the parser to the scaler.
  typedef struct packed {
    logic bad;
    logic neg;
    logic lon;
  } fin_ctl_t;

  function automatic longint unsigned pow10(int n);
    longint unsigned p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/dd2f_parse.sv -----
`include "assert_macros.svh"

module dd2f_parse
  import dd2f_pkg::*;
#(
  parameter int FRAC_DIGITS      = FRAC_DIGITS_DEF,
  parameter int MAX_WHOLE_DIGITS = MAX_WHOLE_DIGITS_DEF,
  localparam int WW  = $clog2(pow10(MAX_WHOLE_DIGITS)),
  localparam int FW  = $clog2(pow10(FRAC_DIGITS)),
  localparam int WCW = $clog2(MAX_WHOLE_DIGITS + 1),
  localparam int FCW = $clog2(FRAC_DIGITS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  logic [7:0]     in_ch,
  input  logic           in_last,
  input  logic           in_lon,
  output logic           fin_vld,
  output fin_ctl_t       fin_ctl,
  output logic [WW-1:0]  fin_whole,
  output logic [FW-1:0]  fin_frac,
  output logic [FCW-1:0] fin_fc
);

  localparam int WXW = WW + 4;
  localparam int FXW = FW + 4;

  logic           at_start_r, at_start_nxt;
  logic           neg_r, neg_nxt;
  logic           infrac_r, infrac_nxt;
  logic           bad_r, bad_nxt;
  logic [WW-1:0]  whole_r, whole_nxt;
  logic [WCW-1:0] wc_r, wc_nxt;
  logic [FW-1:0]  frac_r, frac_nxt;
  logic [FCW-1:0] fc_r, fc_nxt;

  logic           fin_vld_r;
  fin_ctl_t       fin_ctl_r;
  logic [WW-1:0]  fin_whole_r;
  logic [FW-1:0]  fin_frac_r;
  logic [FCW-1:0] fin_fc_r;

  logic           take;
  logic           is_digit;
  logic [3:0]     digit;
  logic [WXW-1:0] whole_x10;
  logic [FXW-1:0] frac_x10;

  assign take      = adv && in_vld;
  assign is_digit  = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign digit     = 4'(in_ch - CH_ZERO);
  assign whole_x10 = (WXW'(whole_r) << 3) + (WXW'(whole_r) << 1) + WXW'(digit);
  assign frac_x10  = (FXW'(frac_r) << 3) + (FXW'(frac_r) << 1) + FXW'(digit);

  always_comb begin
    at_start_nxt = at_start_r;
    neg_nxt      = neg_r;
    infrac_nxt   = infrac_r;
    bad_nxt      = bad_r;
    whole_nxt    = whole_r;
    wc_nxt       = wc_r;
    frac_nxt     = frac_r;
    fc_nxt       = fc_r;
    if (take) begin
      at_start_nxt = 1'b0;
      if (!bad_r) begin
        if (at_start_r && (in_ch == CH_PLUS || in_ch == CH_MINUS)) begin
          neg_nxt = (in_ch == CH_MINUS);
        end else if (is_digit) begin
          if (!infrac_r) begin
            if (wc_r == WCW'(MAX_WHOLE_DIGITS)) begin
              bad_nxt = 1'b1;
            end else begin
              whole_nxt = whole_x10[WW-1:0];
              wc_nxt    = wc_r + 1'b1;
            end
          end else if (fc_r != FCW'(FRAC_DIGITS)) begin
            frac_nxt = frac_x10[FW-1:0];
            fc_nxt   = fc_r + 1'b1;
          end
        end else if (in_ch == CH_POINT && !infrac_r) begin
          infrac_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  // Token state; clear after the last character.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_last)) begin
      at_start_r <= 1'b1;
      neg_r      <= 1'b0;
      infrac_r   <= 1'b0;
      bad_r      <= 1'b0;
      whole_r    <= '0;
      wc_r       <= '0;
      frac_r     <= '0;
      fc_r       <= '0;
    end else begin
      at_start_r <= at_start_nxt;
      neg_r      <= neg_nxt;
      infrac_r   <= infrac_nxt;
      bad_r      <= bad_nxt;
      whole_r    <= whole_nxt;
      wc_r       <= wc_nxt;
      frac_r     <= frac_nxt;
      fc_r       <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= in_vld && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      fin_ctl_r.bad <= bad_nxt || (wc_nxt == '0 && fc_nxt == '0);
      fin_ctl_r.neg <= neg_nxt;
      fin_ctl_r.lon <= in_lon;
      fin_whole_r   <= whole_nxt;
      fin_frac_r    <= frac_nxt;
      fin_fc_r      <= fc_nxt;
    end
  end

  assign fin_vld   = fin_vld_r;
  assign fin_ctl   = fin_ctl_r;
  assign fin_whole = fin_whole_r;
  assign fin_frac  = fin_frac_r;
  assign fin_fc    = fin_fc_r;

  `ASSERT_CLK(a_clear_after_last, (take && in_last) |=> (at_start_r && !bad_r && wc_r == '0 && fc_r == '0), "token state not cleared after last character")
  `ASSERT_NEVER(a_whole_count_bound, wc_r > WCW'(MAX_WHOLE_DIGITS), "whole digit count past limit")

endmodule

// ----- hw/rtl/dd2f_scale.sv -----
`include "assert_macros.svh"

module dd2f_scale
  import dd2f_pkg::*;
#(
  parameter int FRAC_DIGITS      = FRAC_DIGITS_DEF,
  parameter int MAX_WHOLE_DIGITS = MAX_WHOLE_DIGITS_DEF,
  localparam int WW  = $clog2(pow10(MAX_WHOLE_DIGITS)),
  localparam int FW  = $clog2(pow10(FRAC_DIGITS)),
  localparam int FCW = $clog2(FRAC_DIGITS + 1),
  localparam int MW  = $clog2(LON_LIMIT_DEG * pow10(FRAC_DIGITS) + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           fin_vld,
  input  fin_ctl_t       fin_ctl,
  input  logic [WW-1:0]  fin_whole,
  input  logic [FW-1:0]  fin_frac,
  input  logic [FCW-1:0] fin_fc,
  output logic           sc_vld,
  output status_t        sc_status,
  output logic           sc_neg,
  output logic [MW-1:0]  sc_wprod,
  output logic [FW-1:0]  sc_fpad
);

  localparam int CW = (WW > LIMIT_W) ? WW : LIMIT_W;
  localparam logic [MW-1:0] SCALE = MW'(pow10(FRAC_DIGITS));

  logic [CW-1:0]   whole_ext;
  logic [CW-1:0]   limit;
  logic            over;
  status_t         status_nxt;
  logic [FW-1:0]   pad_mult;
  logic [2*FW-1:0] fpad_full;
  logic [MW-1:0]   wprod_nxt;

  logic            vld_r;
  status_t         status_r;
  logic            neg_r;
  logic [MW-1:0]   wprod_r;
  logic [FW-1:0]   fpad_r;

  assign whole_ext = CW'(fin_whole);
  assign limit     = fin_ctl.lon ? CW'(LON_LIMIT_DEG) : CW'(LAT_LIMIT_DEG);
  // Padded fraction stays below one degree, so a whole part at the limit
  // is over only when some fraction digit is nonzero.
  assign over      = (whole_ext > limit) || (whole_ext == limit && fin_frac != '0);

  always_comb begin
    if (fin_ctl.bad) begin
      status_nxt = ST_BAD;
    end else if (over) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Pad the fraction out to the full number of places.
  always_comb begin
    pad_mult = '0;
    for (int k = 0; k <= FRAC_DIGITS; k++) begin
      if (fin_fc == FCW'(k)) begin
        pad_mult = FW'(pow10(FRAC_DIGITS - k));
      end
    end
  end

  assign fpad_full = fin_frac * pad_mult;
  // In range the whole part never exceeds the longitude limit.
  assign wprod_nxt = MW'(fin_whole[WW-1:0] & WW'({LIMIT_W{1'b1}})) * SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_vld) begin
      status_r <= status_nxt;
      neg_r    <= fin_ctl.neg;
      wprod_r  <= wprod_nxt;
      fpad_r   <= fpad_full[FW-1:0];
    end
  end

  assign sc_vld    = vld_r;
  assign sc_status = status_r;
  assign sc_neg    = neg_r;
  assign sc_wprod  = wprod_r;
  assign sc_fpad   = fpad_r;

  `ASSERT_CLK(a_bad_wins, (adv && fin_vld && fin_ctl.bad) |=> (status_r == ST_BAD), "bad syntax not reported as bad")
  `ASSERT_CLK(a_range_flag, (adv && fin_vld && !fin_ctl.bad && whole_ext > limit) |=> (status_r == ST_RANGE), "oversize whole part not flagged out of range")

endmodule

// ----- hw/rtl/dd2f_outq.sv -----
`include "assert_macros.svh"

module dd2f_outq
  import dd2f_pkg::*;
#(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
  localparam int FW = $clog2(pow10(FRAC_DIGITS)),
  localparam int MW = $clog2(LON_LIMIT_DEG * pow10(FRAC_DIGITS) + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sc_vld,
  input  status_t       sc_status,
  input  logic          sc_neg,
  input  logic [MW-1:0] sc_wprod,
  input  logic [FW-1:0] sc_fpad,
  output logic          adv,
  output logic          out_vld,
  input  logic          out_rdy,
  output status_t       out_status,
  output logic [31:0]   out_value
);

  logic [MW-1:0] mag;
  logic [31:0]   mag32;
  logic [31:0]   value_nxt;
  logic          pipe_vld;
  logic          out_take;

  logic          rdy_r;
  logic          out_vld_r, out_vld_nxt;
  status_t       out_status_r;
  logic [31:0]   out_value_r;
  logic          skid_vld_r, skid_vld_nxt;
  status_t       skid_status_r;
  logic [31:0]   skid_value_r;

  assign mag       = sc_wprod + MW'(sc_fpad);
  assign mag32     = 32'(mag);
  assign value_nxt = (sc_status != ST_OK) ? 32'd0 : (sc_neg ? (32'd0 - mag32) : mag32);

  assign adv      = rdy_r;
  assign pipe_vld = rdy_r && sc_vld;
  assign out_take = !out_vld_r || out_rdy;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = pipe_vld;
      end
    end else if (pipe_vld) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r      <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      rdy_r      <= !skid_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_vld_r) begin
        out_status_r <= skid_status_r;
        out_value_r  <= skid_value_r;
      end else if (pipe_vld) begin
        out_status_r <= sc_status;
        out_value_r  <= value_nxt;
      end
    end else if (pipe_vld) begin
      skid_status_r <= sc_status;
      skid_value_r  <= value_nxt;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  `ASSERT_CLK(a_skid_behind_out, skid_vld_r |-> out_vld_r, "skid entry held while output register empty")
  `ASSERT_CLK(a_zero_unless_ok, (out_vld_r && out_status_r != ST_OK) |-> (out_value_r == 32'd0), "nonzero value with failing status")

endmodule

// ----- hw/rtl/decimal_degrees_to_fixed_e7_top.sv -----
// Decimal degrees to fixed point (degrees * 1e7 by default).
//
// Input channel (in_*): one ASCII character of a token per transaction,
// in_tlast on its final character, in_tuser selecting the limit applied on
// that final character (0 latitude +-90, 1 longitude +-180).
// Result channel (out_*): one transaction per token, issued for the
// character marked last only. out_tuser carries the status (0 ok, 1 bad
// syntax, 2 out of range) and out_tdata the signed scaled value, zero
// unless the status is ok.
// Throughput: one character per cycle while in_tready is high. Path: after
// the last character is accepted, the result moves through the input
// register, parse stage, scale stage, then the output register.
// Reset: all token state clears, no result is pending and in_tready comes
// up high in the cycle after rst_n is released.
// Stall: an output register plus one skid entry sit on the result side;
// in_tready drops only once the skid entry is full and the whole pipeline
// holds until the receiver takes a result.
module decimal_degrees_to_fixed_e7_top
  import dd2f_pkg::*;
#(
  parameter int FRAC_DIGITS      = FRAC_DIGITS_DEF,
  parameter int MAX_WHOLE_DIGITS = MAX_WHOLE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  input  logic        in_tuser,   // [0] range_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int WW  = $clog2(pow10(MAX_WHOLE_DIGITS));
  localparam int FW  = $clog2(pow10(FRAC_DIGITS));
  localparam int FCW = $clog2(FRAC_DIGITS + 1);
  localparam int MW  = $clog2(LON_LIMIT_DEG * pow10(FRAC_DIGITS) + 1);

  // Global advance: every stage moves together while the skid entry is free.
  logic           adv;

  // Input register.
  logic           s0_vld_r;
  logic [7:0]     s0_ch_r;
  logic           s0_last_r;
  logic           s0_lon_r;

  // Parse stage to scale stage.
  logic           fin_vld;
  fin_ctl_t       fin_ctl;
  logic [WW-1:0]  fin_whole;
  logic [FW-1:0]  fin_frac;
  logic [FCW-1:0] fin_fc;

  // Scale stage to output stage.
  logic           sc_vld;
  status_t        sc_status;
  logic           sc_neg;
  logic [MW-1:0]  sc_wprod;
  logic [FW-1:0]  sc_fpad;

  status_t        out_status;

  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_tvalid;
    end
  end

  // Capture the character on each accepted transaction.
  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s0_ch_r   <= in_tdata;
      s0_last_r <= in_tlast;
      s0_lon_r  <= in_tuser;
    end
  end

  dd2f_parse #(
    .FRAC_DIGITS      (FRAC_DIGITS),
    .MAX_WHOLE_DIGITS (MAX_WHOLE_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (s0_vld_r),
    .in_ch     (s0_ch_r),
    .in_last   (s0_last_r),
    .in_lon    (s0_lon_r),
    .fin_vld   (fin_vld),
    .fin_ctl   (fin_ctl),
    .fin_whole (fin_whole),
    .fin_frac  (fin_frac),
    .fin_fc    (fin_fc)
  );

  dd2f_scale #(
    .FRAC_DIGITS      (FRAC_DIGITS),
    .MAX_WHOLE_DIGITS (MAX_WHOLE_DIGITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .fin_vld   (fin_vld),
    .fin_ctl   (fin_ctl),
    .fin_whole (fin_whole),
    .fin_frac  (fin_frac),
    .fin_fc    (fin_fc),
    .sc_vld    (sc_vld),
    .sc_status (sc_status),
    .sc_neg    (sc_neg),
    .sc_wprod  (sc_wprod),
    .sc_fpad   (sc_fpad)
  );

  dd2f_outq #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .sc_vld     (sc_vld),
    .sc_status  (sc_status),
    .sc_neg     (sc_neg),
    .sc_wprod   (sc_wprod),
    .sc_fpad    (sc_fpad),
    .adv        (adv),
    .out_vld    (out_tvalid),
    .out_rdy    (out_tready),
    .out_status (out_status),
    .out_value  (out_tdata)
  );

  assign out_tuser = out_status;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dd2f_pkg::*;

  localparam int    HOLD_CYCLES  = 120;   // long output hold-off for the pressure test
  localparam int    STUCK_LIMIT  = 2000;  // cycles without any transaction before giving up
  localparam int    DRAIN_CYCLES = 12;    // quiet cycles after the last result
  localparam int    PRINT_LIMIT  = 40;    // mismatch lines printed before going quiet
  localparam longint unsigned E7 = 64'd10_000_000;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    status_t     status;
    logic [31:0] value;
  } fix_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // DUT inputs, all known from time zero
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  decimal_degrees_to_fixed_e7_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Traffic shaping knobs, set by the test tasks
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int hold_left       = 0;

  int mismatch_count = 0;
  int chars_sent     = 0;
  int stuck_cycles   = 0;

  // Expected results, oldest first
  fix_result_t fix_expected[$];

  // Parser state of the token in progress
  bit          tok_fresh;
  bit          tok_neg;
  bit          tok_frac_part;
  bit          tok_bad;
  logic [33:0] whole_acc;
  logic [3:0]  whole_digits;
  logic [23:0] frac_acc;
  logic [2:0]  frac_digits;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_token();
    tok_fresh     = 1'b1;
    tok_neg       = 1'b0;
    tok_frac_part = 1'b0;
    tok_bad       = 1'b0;
    whole_acc     = '0;
    whole_digits  = '0;
    frac_acc      = '0;
    frac_digits   = '0;
  endtask

  // Advance the parser by one accepted character.
  task automatic track_char(input logic [7:0] c);
    bit lead;
    lead = tok_fresh;
    tok_fresh = 1'b0;
    if (tok_bad)
      return;  // drop everything after a syntax error
    if (lead && (c == CH_PLUS || c == CH_MINUS)) begin
      tok_neg = (c == CH_MINUS);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!tok_frac_part) begin
        if (whole_digits >= MAX_WHOLE_DIGITS_DEF) begin
          tok_bad = 1'b1;
        end else begin
          whole_acc    = whole_acc * 10 + 34'(c - CH_ZERO);
          whole_digits = whole_digits + 4'd1;
        end
      end else if (frac_digits < FRAC_DIGITS_DEF) begin
        // digits past the seventh are swallowed, which truncates
        frac_acc    = frac_acc * 10 + 24'(c - CH_ZERO);
        frac_digits = frac_digits + 3'd1;
      end
    end else if (c == CH_POINT && !tok_frac_part) begin
      tok_frac_part = 1'b1;
    end else begin
      tok_bad = 1'b1;
    end
  endtask

  // Close the token: pad, scale, range-check, queue the result, clear.
  task automatic close_token(input bit lon);
    fix_result_t       r;
    longint unsigned   padded;
    longint unsigned   mag;
    longint unsigned   limit;
    r.status = ST_OK;
    r.value  = '0;
    if (tok_bad || (whole_digits == 0 && frac_digits == 0)) begin
      r.status = ST_BAD;
    end else begin
      padded = frac_acc;
      for (int k = int'(frac_digits); k < FRAC_DIGITS_DEF; k++)
        padded = padded * 10;
      mag   = whole_acc * E7 + padded;
      limit = (lon ? LON_LIMIT_DEG : LAT_LIMIT_DEG) * E7;
      if (mag > limit)
        r.status = ST_RANGE;
      else
        r.value = tok_neg ? (~mag[31:0] + 32'd1) : mag[31:0];
    end
    fix_expected.push_back(r);
    clear_token();
  endtask

  // Offer one character; return at the rising edge that accepts it.
  task automatic send_char(input logic [7:0] c, input bit is_last, input bit lon);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= is_last;
    in_tuser  <= lon;
    // in_tready is stable at the falling edge; the next rising edge accepts
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    track_char(c);
    if (is_last)
      close_token(lon);
    chars_sent++;
  endtask

  // Send a whole token; the range selector only matters on the last character.
  task automatic send_token(input char_q_t t, input bit lon);
    foreach (t[i]) begin
      if (i == t.size() - 1)
        send_char(t[i], 1'b1, lon);
      else
        send_char(t[i], 1'b0, 1'($urandom_range(1)));
    end
  endtask

  task automatic send_text(input string s, input bit lon);
    char_q_t t;
    foreach (s[i]) t.push_back(s[i]);
    send_token(t, lon);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  // Mostly well-formed tokens with random content, some broken, some noise.
  task automatic build_token(output char_q_t t);
    int    pick;
    int    flaw;
    int    n_whole;
    int    n_frac;
    bit    zeros;
    string head;
    t    = {};
    pick = $urandom_range(99);
    if (pick >= 90) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
      return;
    end
    flaw = (pick >= 70) ? $urandom_range(1, 4) : 0;
    case ($urandom_range(2))
      1: t.push_back(CH_PLUS);
      2: t.push_back(CH_MINUS);
      default: ;
    endcase
    if (flaw == 4) begin
      // one digit too many in the whole part, or more
      repeat ($urandom_range(11, 13)) t.push_back(rand_digit());
    end else if ($urandom_range(99) < 20) begin
      // hug the latitude and longitude limits
      case ($urandom_range(5))
        0: head = "89";
        1: head = "90";
        2: head = "91";
        3: head = "179";
        4: head = "180";
        default: head = "181";
      endcase
      foreach (head[i]) t.push_back(head[i]);
    end else begin
      n_whole = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(10);
      repeat (n_whole) t.push_back(rand_digit());
    end
    if ($urandom_range(99) < 65) begin
      t.push_back(CH_POINT);
      n_frac = $urandom_range(10);
      zeros  = ($urandom_range(3) == 0);
      repeat (n_frac) t.push_back(zeros ? CH_ZERO : rand_digit());
    end
    case (flaw)
      1: t.insert($urandom_range(t.size()), $urandom_range(1) ? CH_PLUS : CH_MINUS);
      2: t.insert($urandom_range(t.size()), CH_POINT);
      3: t.insert($urandom_range(t.size()), 8'($urandom_range(255)));
      default: ;
    endcase
    if (t.size() == 0)
      t.push_back(rand_digit());
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin : receiver
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction; sample at the falling edge, where
  // everything driven at the rising edge has settled.
  always @(negedge clk) begin : result_check
    fix_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fix_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d",
                                  out_tuser, $signed(out_tdata)));
      end else begin
        want = fix_expected.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        if (out_tdata !== want.value)
          report_mismatch($sformatf("value %0d, want %0d",
                                    $signed(out_tdata), $signed(want.value)));
      end
    end
  end

  // Watchdog: give up when no transaction moves on either side for too long.
  always @(negedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stuck_cycles = 0;
      else
        stuck_cycles = stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no transaction in %0d cycles, %0d results pending",
                 STUCK_LIMIT, fix_expected.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Field extremes and the corner cases of the syntax.
  task automatic test_directed();
    char_q_t t;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_text("-0", 1'b0);                  // negative zero is plain zero
    send_text(".", 1'b1);                   // lone point, no digits at all
    send_text("-180", 1'b1);                // most negative longitude
    send_text("90.1", 1'b0);                // just past the latitude limit
    send_text("9-", 1'b1);                  // sign after a digit
    send_text("..", 1'b0);                  // second point
    send_text(".12345678", 1'b1);           // eighth fraction digit dropped
    t = {8'hFF, 8'h00};                     // junk, then ignored junk
    send_token(t, 1'b1);
    send_text("99999999999", 1'b1);         // eleventh whole digit beats range
  endtask

  task automatic test_random(input int n_chars, input int idle_pct, input int stall_pct);
    char_q_t t;
    int      stop_at;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    stop_at         = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      build_token(t);
      send_token(t, 1'($urandom_range(1)));
    end
  endtask

  // Hold the output off while single-digit tokens keep coming, so the
  // result side fills and in_tready drops.
  task automatic test_backpressure();
    char_q_t t;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    in_tvalid <= 1'b0;
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    repeat (40) begin
      t = {rand_digit()};
      send_token(t, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    clear_token();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(265, 0, 0);
    test_random(265, 87, 0);
    test_random(265, 0, 87);
    test_backpressure();
    test_random(265, 13, 13);

    // Drop valid, drain the pipeline, then let stragglers show up.
    in_tvalid <= 1'b0;
    while (fix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- decimal_degrees_to_fixed_e7_top.f -----
+incdir+hw/rtl
hw/rtl/dd2f_pkg.sv
hw/rtl/dd2f_parse.sv
hw/rtl/dd2f_scale.sv
hw/rtl/dd2f_outq.sv
hw/rtl/decimal_degrees_to_fixed_e7_top.sv
tb/testbench.sv
